// ===== sv/gld_pkg.sv =====
// shared constants for the grid local maximum detector
package gld_pkg;

  // default sizes handed to the top level
  localparam int MAX_DIM_DEF    = 64;
  localparam int VALUE_BITS_DEF = 32;

  // result queue: depth is a power of two, up to three results per word
  localparam int PEAK_FIFO_DEPTH = 8;
  localparam int MAX_PEAKS       = 3;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } reg_idx_t;

endpackage

// ===== sv/gld_line_store.sv =====
// two line stores of the previous rows with registered reads and write bypass
module gld_line_store #(
  parameter int DEPTH = gld_pkg::MAX_DIM_DEF,
  parameter int AW    = $clog2(gld_pkg::MAX_DIM_DEF),
  parameter int VB    = gld_pkg::VALUE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic signed [VB-1:0] wr_prev,
  input  logic signed [VB-1:0] wr_prev2,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr_a,
  input  logic [AW-1:0]        rd_addr_b,
  output logic signed [VB-1:0] rd_prev_a_r,
  output logic signed [VB-1:0] rd_prev2_a_r,
  output logic signed [VB-1:0] rd_prev_b_r
);

  logic signed [VB-1:0] mem_prev  [DEPTH];
  logic signed [VB-1:0] mem_prev2 [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_prev[wr_addr]  <= wr_prev;
      mem_prev2[wr_addr] <= wr_prev2;
    end
  end

  // read ports, a write to the same column in this cycle is passed straight on
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr_a)) begin
        rd_prev_a_r  <= wr_prev;
        rd_prev2_a_r <= wr_prev2;
      end else begin
        rd_prev_a_r  <= mem_prev[rd_addr_a];
        rd_prev2_a_r <= mem_prev2[rd_addr_a];
      end
      if (wr_en && (wr_addr == rd_addr_b)) begin
        rd_prev_b_r <= wr_prev;
      end else begin
        rd_prev_b_r <= mem_prev[rd_addr_b];
      end
    end
  end

endmodule

// ===== sv/gld_peak_fifo.sv =====
// result queue that packs up to three peak reports per cycle in the order of their push slots
module gld_peak_fifo #(
  parameter int IW = $clog2(gld_pkg::MAX_DIM_DEF)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [2:0]    push_hit,
  input  logic [IW-1:0] push_row [gld_pkg::MAX_PEAKS],
  input  logic [IW-1:0] push_col [gld_pkg::MAX_PEAKS],
  output logic [$clog2(gld_pkg::PEAK_FIFO_DEPTH+1)-1:0] count_r,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [IW-1:0] out_peak_row,
  output logic [IW-1:0] out_peak_col,
  output logic          out_last_of_run
);

  localparam int DEPTH = gld_pkg::PEAK_FIFO_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  logic [IW-1:0] ent_row_r  [DEPTH];
  logic [IW-1:0] ent_col_r  [DEPTH];
  logic          ent_last_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_nxt;
  logic [1:0]    slot_off [gld_pkg::MAX_PEAKS];
  logic [1:0]    push_n;
  logic          is_last [gld_pkg::MAX_PEAKS];
  logic          pop;

  // slot of each hit among this cycle's hits, and which one closes the run
  always_comb begin
    slot_off[0] = 2'd0;
    slot_off[1] = {1'b0, push_hit[0]};
    slot_off[2] = 2'(push_hit[0]) + 2'(push_hit[1]);
    push_n      = slot_off[2] + 2'(push_hit[2]);
    is_last[0]  = push_hit[0] && !push_hit[1] && !push_hit[2];
    is_last[1]  = push_hit[1] && !push_hit[2];
    is_last[2]  = push_hit[2];
  end

  assign pop        = out_valid && out_ready;
  assign wr_ptr_nxt = wr_ptr_r + PW'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + PW'(pop);
  assign count_nxt  = count_r + NW'(push_n) - NW'(pop);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry writes
  always_ff @(posedge clk) begin
    for (int k = 0; k < gld_pkg::MAX_PEAKS; k++) begin
      if (push_hit[k]) begin
        ent_row_r[wr_ptr_r + PW'(slot_off[k])]  <= push_row[k];
        ent_col_r[wr_ptr_r + PW'(slot_off[k])]  <= push_col[k];
        ent_last_r[wr_ptr_r + PW'(slot_off[k])] <= is_last[k];
      end
    end
  end

  // head of the queue
  assign out_valid       = (count_r != '0);
  assign out_peak_row    = ent_row_r[rd_ptr_r];
  assign out_peak_col    = ent_col_r[rd_ptr_r];
  assign out_last_of_run = ent_last_r[rd_ptr_r];

endmodule

// ===== sv/grid_local_maximum_detect.sv =====
// top level of the four-neighbour grid local maximum detector
//
// Signed values arrive one word per cycle in raster order for a grid of
// grid_rows by grid_cols cells; every cell that is not below any of its
// existing up, down, left and right neighbours is reported by row and column
// once its last neighbour arrives, with last_of_run set on the final report
// caused by a word. While in_ready is high the block takes one word per
// cycle: the accept cycle reads the two line stores, the next cycle compares
// and pushes up to three reports into an eight-entry result queue. in_ready
// drops only while the result queue could not take three more reports, which
// the consumer sets by how fast it drains out_*. A write to either register
// restarts the grid at cell (0,0); the low $clog2(MAX_DIM+1) bits of pwdata
// are used, a field of 0 reads as 1 and one above MAX_DIM as MAX_DIM. Line
// stores need no clearing pass after reset.
module grid_local_maximum_detect #(
  parameter int MAX_DIM    = gld_pkg::MAX_DIM_DEF,
  parameter int VALUE_BITS = gld_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input word
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] in_cell_value,
  // result word
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [$clog2(MAX_DIM)-1:0]   out_peak_row,
  output logic [$clog2(MAX_DIM)-1:0]   out_peak_col,
  output logic                         out_last_of_run,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int NW = $clog2(gld_pkg::PEAK_FIFO_DEPTH + 1);
  localparam int SW = NW + 1;

  logic [DW-1:0] grid_rows_r, grid_cols_r;
  logic [CW-1:0] row_r, row_nxt, col_r, col_nxt;
  logic          cfg_wr;
  logic          in_acc;

  logic                         s1_valid_r;
  logic signed [VALUE_BITS-1:0] s1_val_r;
  logic [CW-1:0]                s1_row_r, s1_col_r;

  logic signed [VALUE_BITS-1:0] lh_up_r, lh_val_r, lh_val2_r;
  logic signed [VALUE_BITS-1:0] above, above2, right_val;

  logic [NW-1:0] fifo_count;
  logic [2:0]    hit;
  logic [CW-1:0] push_row [gld_pkg::MAX_PEAKS];
  logic [CW-1:0] push_col [gld_pkg::MAX_PEAKS];

  logic          has_up, has_up2, has_left, has_left2, has_right;
  logic          last_row, last_col;
  logic [DW-1:0] col_inc, row_inc;

  // register value range limit
  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
    logic [DW-1:0] res;
    res = v;
    if (v == '0) begin
      res = DW'(1);
    end else if (v > DW'(MAX_DIM)) begin
      res = DW'(MAX_DIM);
    end
    return res;
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= DW'(1);
      grid_cols_r <= DW'(1);
    end else if (cfg_wr) begin
      unique case (gld_pkg::reg_idx_t'(paddr[2]))
        gld_pkg::REG_GRID_ROWS: grid_rows_r <= clamp_dim(pwdata[DW-1:0]);
        gld_pkg::REG_GRID_COLS: grid_cols_r <= clamp_dim(pwdata[DW-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (gld_pkg::reg_idx_t'(paddr[2]))
      gld_pkg::REG_GRID_ROWS: prdata = 32'(grid_rows_r);
      gld_pkg::REG_GRID_COLS: prdata = 32'(grid_cols_r);
      default:                prdata = '0;
    endcase
  end

  // accept while the queue can still take three reports from each word in flight
  assign in_ready = (SW'(fifo_count) + (s1_valid_r ? SW'(gld_pkg::MAX_PEAKS) : SW'(0)))
                    <= SW'(gld_pkg::PEAK_FIFO_DEPTH - gld_pkg::MAX_PEAKS);
  assign in_acc   = in_valid && in_ready;

  // raster position of the next word
  always_comb begin
    col_inc = DW'(col_r) + DW'(1);
    row_inc = DW'(row_r) + DW'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (col_inc == grid_cols_r) begin
        col_nxt = '0;
        row_nxt = (row_inc == grid_rows_r) ? '0 : row_inc[CW-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cfg_wr) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_val_r <= in_cell_value;
      s1_row_r <= row_r;
      s1_col_r <= col_r;
    end
  end

  // previous two rows
  gld_line_store #(
    .DEPTH (MAX_DIM),
    .AW    (CW),
    .VB    (VALUE_BITS)
  ) u_line_store (
    .clk          (clk),
    .wr_en        (s1_valid_r),
    .wr_addr      (s1_col_r),
    .wr_prev      (s1_val_r),
    .wr_prev2     (above),
    .rd_en        (in_acc),
    .rd_addr_a    (col_r),
    .rd_addr_b    (col_r + CW'(1)),
    .rd_prev_a_r  (above),
    .rd_prev2_a_r (above2),
    .rd_prev_b_r  (right_val)
  );

  // neighbour presence for the word in the input register
  always_comb begin
    has_up    = (s1_row_r != '0);
    has_up2   = (s1_row_r > CW'(1));
    has_left  = (s1_col_r != '0);
    has_left2 = (s1_col_r > CW'(1));
    has_right = (DW'(s1_col_r) + DW'(1)) < grid_cols_r;
    last_row  = DW'(s1_row_r) == (grid_rows_r - DW'(1));
    last_col  = DW'(s1_col_r) == (grid_cols_r - DW'(1));
  end

  // peak tests: cell above, last-row cell to the left, final cell of the grid
  always_comb begin
    hit[0] = s1_valid_r && has_up
             && !(has_up2   && (above < above2))
             && !(has_left  && (above < lh_up_r))
             && !(has_right && (above < right_val))
             && !(above < s1_val_r);
    hit[1] = s1_valid_r && last_row && has_left
             && !(has_up    && (lh_val_r < lh_up_r))
             && !(has_left2 && (lh_val_r < lh_val2_r))
             && !(lh_val_r < s1_val_r);
    hit[2] = s1_valid_r && last_row && last_col
             && !(has_up   && (s1_val_r < above))
             && !(has_left && (s1_val_r < lh_val_r));
    push_row[0] = s1_row_r - CW'(1);
    push_col[0] = s1_col_r;
    push_row[1] = s1_row_r;
    push_col[1] = s1_col_r - CW'(1);
    push_row[2] = s1_row_r;
    push_col[2] = s1_col_r;
  end

  // values held from the last words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lh_up_r   <= '0;
      lh_val_r  <= '0;
      lh_val2_r <= '0;
    end else if (s1_valid_r) begin
      lh_up_r   <= above;
      lh_val_r  <= s1_val_r;
      lh_val2_r <= lh_val_r;
    end
  end

  // result queue
  gld_peak_fifo #(
    .IW (CW)
  ) u_peak_fifo (
    .clk             (clk),
    .rst_n           (rst_n),
    .push_hit        (hit),
    .push_row        (push_row),
    .push_col        (push_col),
    .count_r         (fifo_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_peak_row    (out_peak_row),
    .out_peak_col    (out_peak_col),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== tb/tb.sv =====
// testbench for the grid local maximum detector: random grids checked against a predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM           = 64;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_WORDS  = 450;

  typedef struct packed {
    logic [5:0] row;
    logic [5:0] col;
    logic       last;
  } peak_t;

  typedef enum int {
    VAL_NARROW,
    VAL_FULL,
    VAL_EXTREME
  } value_mode_t;

  logic               clk;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  wire                in_ready;
  logic signed [31:0] in_cell_value = '0;
  wire                out_valid;
  logic               out_ready     = 1'b0;
  wire  [5:0]         out_peak_row;
  wire  [5:0]         out_peak_col;
  wire                out_last_of_run;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [2:0]         paddr         = '0;
  logic [31:0]        pwdata        = '0;
  wire  [31:0]        prdata;
  wire                pready;

  // predicted state of the detector
  logic signed [31:0] prev_row  [DIM];
  logic signed [31:0] prev_row2 [DIM];
  logic signed [31:0] left_up   = '0;
  logic signed [31:0] left_val  = '0;
  int                 row_pos   = 0;
  int                 col_pos   = 0;
  int                 rows_eff  = 1;
  int                 cols_eff  = 1;

  logic signed [31:0] cell_queue     [$];
  peak_t              expected_peaks [$];
  int                 errors    = 0;
  int                 cycles    = 0;
  bit                 steady    = 1'b0;
  int                 in_gap    = 0;
  int                 out_stall = 0;

  grid_local_maximum_detect u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cell_value   (in_cell_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_peak_row    (out_peak_row),
    .out_peak_col    (out_peak_col),
    .out_last_of_run (out_last_of_run),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 40) $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // idle cycles for the word driver and the result monitor, none while a steady stretch runs
  function automatic int draw_wait();
    if (steady) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
  endfunction

  // works out the peaks reported for one accepted word and advances the raster position
  task automatic predict_peaks(input logic signed [31:0] v);
    peak_t              found [$];
    logic signed [31:0] above;
    logic signed [31:0] above2;
    logic               ok;
    int                 r;
    int                 c;
    r = row_pos;
    c = col_pos;
    if (r >= rows_eff || c >= cols_eff) begin
      r = 0;
      c = 0;
    end
    above  = prev_row[c];
    above2 = prev_row2[c];
    // cell above: its lower neighbour has just come in
    if (r >= 1) begin
      ok = 1'b1;
      if (r >= 2 && above < above2) ok = 1'b0;
      if (c >= 1 && above < left_up) ok = 1'b0;
      if (c + 1 < cols_eff && above < prev_row[c + 1]) ok = 1'b0;
      if (above < v) ok = 1'b0;
      if (ok) found.push_back('{6'(r - 1), 6'(c), 1'b0});
    end
    // last row: the cell to the left now has its right neighbour
    if (r == rows_eff - 1 && c >= 1) begin
      ok = 1'b1;
      if (r >= 1 && left_val < prev_row2[c - 1]) ok = 1'b0;
      if (c >= 2 && left_val < prev_row[c - 2]) ok = 1'b0;
      if (left_val < v) ok = 1'b0;
      if (ok) found.push_back('{6'(r), 6'(c - 1), 1'b0});
    end
    // final cell of the grid
    if (r == rows_eff - 1 && c == cols_eff - 1) begin
      ok = 1'b1;
      if (r >= 1 && v < above) ok = 1'b0;
      if (c >= 1 && v < left_val) ok = 1'b0;
      if (ok) found.push_back('{6'(r), 6'(c), 1'b0});
    end
    if (found.size() > 0) found[found.size() - 1].last = 1'b1;
    foreach (found[i]) expected_peaks.push_back(found[i]);
    left_up      = above;
    left_val     = v;
    prev_row2[c] = above;
    prev_row[c]  = v;
    c++;
    if (c >= cols_eff) begin
      c = 0;
      r++;
      if (r >= rows_eff) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endtask

  // word driver: holds each word until taken, then waits its drawn gap
  always @(posedge clk) begin : word_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) predict_peaks(in_cell_value);
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (cell_queue.size() > 0) begin
        in_cell_value <= cell_queue.pop_front();
        in_valid      <= 1'b1;
        in_gap        <= draw_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor: checks each peak word, then stalls for a drawn time
  always @(posedge clk) begin : result_monitor
    peak_t want;
    int    w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_peaks.size() == 0) begin
        report_mismatch($sformatf("unexpected peak at (%0d,%0d)", out_peak_row, out_peak_col));
      end else begin
        want = expected_peaks.pop_front();
        if (out_peak_row !== want.row)
          report_mismatch($sformatf("peak_row %0d, wanted %0d", out_peak_row, want.row));
        if (out_peak_col !== want.col)
          report_mismatch($sformatf("peak_col %0d, wanted %0d", out_peak_col, want.col));
        if (out_last_of_run !== want.last)
          report_mismatch($sformatf("last_of_run %0b, wanted %0b at (%0d,%0d)",
                                    out_last_of_run, want.last, want.row, want.col));
      end
      w = draw_wait();
      if (w > 0) begin
        out_ready <= 1'b0;
        out_stall <= w;
      end
    end else if (!out_ready) begin
      if (out_stall <= 1) out_ready <= 1'b1;
      out_stall <= out_stall - 1;
    end
  end

  // register write over the config port; the grid restarts on every write
  task automatic cfg_write(input gld_pkg::reg_idx_t idx, input logic [31:0] value);
    int dim;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    dim = value[6:0];
    if (dim == 0) dim = 1;
    else if (dim > DIM) dim = DIM;
    if (idx == gld_pkg::REG_GRID_ROWS) rows_eff = dim;
    else cols_eff = dim;
    row_pos = 0;
    col_pos = 0;
  endtask

  task automatic set_grid(input logic [31:0] rows_raw, input logic [31:0] cols_raw);
    if ($urandom_range(0, 1)) begin
      cfg_write(gld_pkg::REG_GRID_ROWS, rows_raw);
      cfg_write(gld_pkg::REG_GRID_COLS, cols_raw);
    end else begin
      cfg_write(gld_pkg::REG_GRID_COLS, cols_raw);
      cfg_write(gld_pkg::REG_GRID_ROWS, rows_raw);
    end
  endtask

  // block drained: no word pending, no peak outstanding, pipeline flushed
  task automatic wait_idle();
    while (cell_queue.size() > 0 || in_valid || expected_peaks.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] oversize_raw();
    return ($urandom() & 32'hffff_ff80) | $urandom_range(64, 127);
  endfunction

  function automatic logic [31:0] small_raw();
    if ($urandom_range(0, 7) == 0) return $urandom() & 32'hffff_ff80;
    return $urandom_range(1, 6);
  endfunction

  function automatic logic [31:0] pick_value(input value_mode_t mode);
    case (mode)
      VAL_NARROW: return 32'($signed($urandom_range(0, 6)) - 3);
      VAL_FULL:   return $urandom();
      default: begin
        case ($urandom_range(0, 5))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0000_0000;
          3:       return 32'hffff_ffff;
          4:       return 32'h8000_0001;
          default: return 32'h7fff_fffe;
        endcase
      end
    endcase
  endfunction

  // stimulus
  initial begin : stimulus
    int          sent;
    int          kind;
    int          words;
    value_mode_t mode;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset size is one by one: every word is a grid of its own
    steady = 1'b1;
    cell_queue.push_back(32'sh8000_0000);
    cell_queue.push_back(32'sh7fff_ffff);
    cell_queue.push_back(32'sh0000_0000);
    wait_idle();

    // single row, rows written as zero
    steady = 1'b0;
    set_grid(32'd0, 32'd5);
    cell_queue.push_back(32'sh7fff_ffff);
    cell_queue.push_back(32'sh8000_0000);
    cell_queue.push_back(32'sh7fff_ffff);
    cell_queue.push_back(32'sh7fff_ffff);
    cell_queue.push_back(32'sh8000_0000);
    wait_idle();

    // single column, cols written with only bits above the field set
    set_grid(32'd4, 32'h0000_0080);
    cell_queue.push_back(32'sh8000_0000);
    cell_queue.push_back(32'sd5);
    cell_queue.push_back(32'sd5);
    cell_queue.push_back(32'shffff_ffff);
    wait_idle();

    // flat three by three: every cell a peak, three at the final word
    set_grid(32'd3, 32'd3);
    repeat (9) cell_queue.push_back(32'shffff_ffff);

    // random grids
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      wait_idle();
      steady = ($urandom_range(0, 4) == 0);
      kind   = $urandom_range(0, 9);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: mode = VAL_FULL;
        5, 6, 7:       mode = VAL_EXTREME;
        default:       mode = VAL_NARROW;
      endcase
      if (kind == 0) begin
        // tall grid
        set_grid(oversize_raw(), $urandom_range(1, 2));
        words = rows_eff * cols_eff;
      end else if (kind == 1) begin
        // wide grid
        set_grid($urandom_range(1, 2), ($urandom_range(0, 1)) ? 32'd64 : oversize_raw());
        words = rows_eff * cols_eff;
      end else begin
        set_grid(small_raw(), small_raw());
        words = rows_eff * cols_eff * $urandom_range(1, 3);
        if ($urandom_range(0, 4) == 0) words = $urandom_range(1, rows_eff * cols_eff * 2);
      end
      repeat (words) cell_queue.push_back(pick_value(mode));
      sent += words;
    end

    wait_idle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/gld_pkg.sv
sv/gld_line_store.sv
sv/gld_peak_fifo.sv
sv/grid_local_maximum_detect.sv
tb/tb.sv
